// File: design/kdpr_pkg.sv
// Shared types and constants for the keypad debounce block.
package kdpr_pkg;

  localparam int unsigned NumButtons = 8;
  localparam int unsigned KeyW       = $clog2(NumButtons);

  // Key codes follow the pin bit numbers
  typedef enum logic [KeyW-1:0] {
    KEY_STANDBY = 3'd0,
    KEY_MENU    = 3'd1,
    KEY_SET     = 3'd2,
    KEY_SELECT  = 3'd3,
    KEY_UP      = 3'd4,
    KEY_DOWN    = 3'd5,
    KEY_LEFT    = 3'd6,
    KEY_RIGHT   = 3'd7
  } key_code_e;

  // Per-button detection flags for the sample being taken
  typedef struct packed {
    logic [NumButtons-1:0] press;
    logic [NumButtons-1:0] hold;
  } btn_flags_t;

endpackage

// File: design/kdpr_history.sv
// Per-button sample history shift registers with press and hold detection.
module kdpr_history #(
  parameter int unsigned STABLE_SAMPLES = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           shift_i,
  input  logic [kdpr_pkg::NumButtons-1:0] pin_levels_i,
  output kdpr_pkg::btn_flags_t           flags_o
);
  import kdpr_pkg::*;

  localparam int unsigned HistW = STABLE_SAMPLES + 1;
  localparam logic [HistW-1:0] PressPattern = {1'b1, {STABLE_SAMPLES{1'b0}}};
  localparam logic [HistW-1:0] HoldPattern  = '0;

  logic [HistW-1:0] hist_q [NumButtons];
  logic [HistW-1:0] hist_d [NumButtons];

  // Shift the new level in at bit 0 and test the resulting history
  always_comb begin
    for (int b = 0; b < NumButtons; b++) begin
      hist_d[b]        = {hist_q[b][HistW-2:0], pin_levels_i[b]};
      flags_o.press[b] = (hist_d[b] == PressPattern);
      flags_o.hold[b]  = (hist_d[b] == HoldPattern);
    end
  end

  // Advance all histories on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NumButtons; b++) begin
        hist_q[b] <= '0;
      end
    end else if (shift_i) begin
      for (int b = 0; b < NumButtons; b++) begin
        hist_q[b] <= hist_d[b];
      end
    end
  end

endmodule

// File: design/kdpr_pick.sv
// Fixed-priority key selection with auto-repeat for left and right.
module kdpr_pick (
  input  kdpr_pkg::btn_flags_t        flags_i,
  input  logic                        repeat_mode_i,
  output logic                        key_valid_o,
  output logic [kdpr_pkg::KeyW-1:0]   key_code_o
);
  import kdpr_pkg::*;

  logic [NumButtons-1:0] hit;

  // Every button reports a press; left and right also report a hold in repeat mode
  always_comb begin
    hit = flags_i.press;
    hit[KEY_LEFT]  = flags_i.press[KEY_LEFT]  | (repeat_mode_i & flags_i.hold[KEY_LEFT]);
    hit[KEY_RIGHT] = flags_i.press[KEY_RIGHT] | (repeat_mode_i & flags_i.hold[KEY_RIGHT]);
  end

  // Highest button number wins
  always_comb begin
    key_valid_o = 1'b0;
    key_code_o  = KEY_STANDBY;
    for (int b = 0; b < NumButtons; b++) begin
      if (hit[b]) begin
        key_valid_o = 1'b1;
        key_code_o  = KeyW'(b);
      end
    end
  end

endmodule

// File: design/keypad_debounce_priority_repeat.sv
// Keypad debounce top level: history bank, key selection and result register.
// One request is one sample tick of the eight active-low button pins and yields
// exactly one result (key_valid, key_code) in the cycle after it is accepted.
// A new request is taken every cycle while the result register is empty or being
// drained, so the sustained rate is one tick per clock; the shift, compare and
// priority pick for a tick sit between the history registers and the result register.
// A press is one released sample followed by STABLE_SAMPLES pressed samples; after
// reset every history reads as fully pressed. The repeat_mode register resets to 1
// and is written through the cfg channel, which is always ready.
module keypad_debounce_priority_repeat #(
  parameter int unsigned STABLE_SAMPLES = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_repeat_mode_i,
  // Sample requests
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [kdpr_pkg::NumButtons-1:0]   pin_levels_i,
  // Key results
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              key_valid_o,
  output logic [kdpr_pkg::KeyW-1:0]         key_code_o
);
  import kdpr_pkg::*;

  btn_flags_t        flags;
  logic              repeat_mode_q;
  logic              out_valid_q;
  logic              key_valid_q, key_valid_d;
  logic [KeyW-1:0]   key_code_q, key_code_d;
  logic              accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  kdpr_history #(
    .STABLE_SAMPLES(STABLE_SAMPLES)
  ) u_history (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .shift_i      (accept),
    .pin_levels_i (pin_levels_i),
    .flags_o      (flags)
  );

  kdpr_pick u_pick (
    .flags_i       (flags),
    .repeat_mode_i (repeat_mode_q),
    .key_valid_o   (key_valid_d),
    .key_code_o    (key_code_d)
  );

  // Hold the repeat mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_mode_q <= 1'b1;
    end else if (cfg_valid_i) begin
      repeat_mode_q <= cfg_repeat_mode_i;
    end
  end

  // Track result occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // Capture the result payload on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_valid_q <= key_valid_d;
      key_code_q  <= key_code_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_valid_o = key_valid_q;
  assign key_code_o  = key_code_q;

endmodule

// File: test/keypad_debounce_priority_repeat_tb.sv
// Self-checking testbench for the keypad debounce, priority and repeat block.
module keypad_debounce_priority_repeat_tb;
  import kdpr_pkg::*;

  localparam int unsigned StableSamples = 12;
  localparam int unsigned HistW         = StableSamples + 1;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned MaxReported   = 10;

  // One released sample followed by a full run of pressed samples
  localparam logic [HistW-1:0] PressPattern = HistW'(1) << StableSamples;
  localparam logic [HistW-1:0] HoldPattern  = '0;

  typedef struct packed {
    logic      valid;
    key_code_e code;
  } key_event_t;

  logic                  clk;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic                  cfg_repeat_mode_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [NumButtons-1:0] pin_levels_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  key_valid_o;
  logic [KeyW-1:0]       key_code_o;

  // Predictor state: per-button sample history and the repeat setting
  logic [HistW-1:0] btn_hist [NumButtons];
  logic             repeat_on;
  key_event_t       expected_keys [$];

  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned samples_sent;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_off_len;
  int unsigned hold_off_id;
  int unsigned hold_off_seen;
  int unsigned hold_off_left;

  keypad_debounce_priority_repeat #(
    .STABLE_SAMPLES(StableSamples)
  ) u_top (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_repeat_mode_i(cfg_repeat_mode_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pin_levels_i     (pin_levels_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .key_valid_o      (key_valid_o),
    .key_code_o       (key_code_o)
  );

  // Generate the clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shift one tick into every history and pick the highest reporting key
  function automatic key_event_t debounce_tick(logic [NumButtons-1:0] levels);
    key_event_t       ev;
    logic [HistW-1:0] h;
    logic             hit;
    ev.valid = 1'b0;
    ev.code  = KEY_STANDBY;
    for (int b = 0; b < NumButtons; b++) begin
      h           = {btn_hist[b][HistW-2:0], levels[b]};
      btn_hist[b] = h;
      hit = (h == PressPattern) ||
            (h == HoldPattern && repeat_on && (b == KEY_LEFT || b == KEY_RIGHT));
      if (hit) begin
        ev.valid = 1'b1;
        ev.code  = key_code_e'(b);
      end
    end
    return ev;
  endfunction

  function automatic void log_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReported) begin
      $display("%s", msg);
    end
  endfunction

  // Check results, predict accepted requests, track register writes
  always @(posedge clk) begin : monitor
    key_event_t exp_ev;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_keys.size() == 0) begin
          log_mismatch($sformatf("unexpected result: valid=%0b code=%0d",
                                 key_valid_o, key_code_o));
        end else begin
          exp_ev = expected_keys.pop_front();
          if (key_valid_o !== exp_ev.valid || key_code_o !== exp_ev.code) begin
            log_mismatch($sformatf(
              "mismatch: expected valid=%0b code=%0d, got valid=%0b code=%0d",
              exp_ev.valid, exp_ev.code, key_valid_o, key_code_o));
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_keys.push_back(debounce_tick(pin_levels_i));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        repeat_on = cfg_repeat_mode_i;
      end
      // Abort when no channel moves for too long
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("keypad_debounce_priority_repeat_tb: FAIL");
          $finish;
        end
      end
    end
  end

  // Drive the result ready: long hold-offs on request, random stalls otherwise
  always @(negedge clk) begin
    if (hold_off_id != hold_off_seen) begin
      hold_off_seen <= hold_off_id;
      hold_off_left <= hold_off_len;
      out_ready_i   <= 1'b0;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
      out_ready_i   <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one sample tick and hold it until accepted; called at a falling edge
  task automatic send_sample(input logic [NumButtons-1:0] levels);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk);
    end
    in_valid_i   <= 1'b1;
    pin_levels_i <= levels;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    @(negedge clk);
    samples_sent++;
  endtask

  // Drop the request and wait until every result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_keys.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_repeat_mode(input logic mode);
    wait_drained();
    cfg_valid_i       <= 1'b1;
    cfg_repeat_mode_i <= mode;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  // Press a random set of buttons with staggered starts and hold them for a random length
  task automatic send_burst();
    logic [NumButtons-1:0] mask;
    logic [NumButtons-1:0] lv;
    logic [KeyW-1:0]       flip;
    int unsigned           len;
    int unsigned           offs [NumButtons];
    mask = NumButtons'($urandom);
    len  = ($urandom_range(3) == 0) ? $urandom_range(2, 12) : $urandom_range(13, 20);
    for (int b = 0; b < NumButtons; b++) offs[b] = $urandom_range(3);
    for (int i = 0; i <= len; i++) begin
      lv = '1;
      for (int b = 0; b < NumButtons; b++) begin
        if (mask[b] && i > offs[b]) lv[b] = 1'b0;
      end
      // Bounce a contact now and then
      if ($urandom_range(15) == 0) begin
        flip     = KeyW'($urandom_range(NumButtons-1));
        lv[flip] = ~lv[flip];
      end
      send_sample(lv);
    end
  endtask

  // All histories start as held: left and right repeat at once, others stay quiet
  task automatic test_reset_hold();
    send_idle_pct <= 20;
    recv_idle_pct <= 20;
    send_sample(8'h00);
    send_sample(8'h7F);
    send_sample(8'h3F);
    send_sample(8'hFF);
  endtask

  // Stagger presses from right down to standby so every key reports its press
  task automatic test_press_priority();
    logic [NumButtons-1:0] lv;
    write_repeat_mode(1'b0);
    send_sample(8'hFF);
    for (int i = 1; i <= StableSamples + NumButtons - 1; i++) begin
      for (int b = 0; b < NumButtons; b++) lv[b] = (i < NumButtons - b);
      send_sample(lv);
    end
  endtask

  // Stall the receiver while requests keep coming, then pause until drained
  task automatic test_backpressure();
    write_repeat_mode(1'b1);
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    hold_off_len  <= 40;
    hold_off_id   <= hold_off_id + 1;
    send_sample(8'hFF);
    for (int i = 0; i < 29; i++) send_sample(8'h3F);
    wait_drained();
    for (int i = 0; i < 6; i++) send_sample(8'hFF);
  endtask

  task automatic test_random_phase(input int unsigned snd_pct, input int unsigned rcv_pct,
                                   input logic mode, input int unsigned count);
    int unsigned start;
    write_repeat_mode(mode);
    send_idle_pct <= snd_pct;
    recv_idle_pct <= rcv_pct;
    start = samples_sent;
    while (samples_sent - start < count) begin
      if ($urandom_range(9) == 0) begin
        send_sample(NumButtons'($urandom));
      end else begin
        send_burst();
      end
    end
  endtask

  initial begin
    clk               = 1'b0;
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_repeat_mode_i = 1'b0;
    in_valid_i        = 1'b0;
    pin_levels_i      = '1;
    out_ready_i       = 1'b0;
    repeat_on         = 1'b1;
    mismatch_count    = 0;
    idle_cycles       = 0;
    samples_sent      = 0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    hold_off_len      = 0;
    hold_off_id       = 0;
    hold_off_seen     = 0;
    hold_off_left     = 0;
    for (int b = 0; b < NumButtons; b++) btn_hist[b] = '0;

    // Hold reset low, then release it
    repeat (2) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    test_reset_hold();
    test_press_priority();
    test_backpressure();
    test_random_phase(9, 63, 1'b1, 360);
    test_random_phase(63, 9, 1'b0, 360);
    test_random_phase(0, 0, 1'b1, 180);
    test_random_phase(0, 0, 1'b0, 180);

    wait_drained();
    repeat (4) @(negedge clk);
    if (mismatch_count == 0 && expected_keys.size() == 0) begin
      $display("keypad_debounce_priority_repeat_tb: PASS");
    end else begin
      $display("keypad_debounce_priority_repeat_tb: FAIL");
    end
    $finish;
  end

endmodule
